[sv/hes_pkg.sv]
// ----------------------------------------------------------------------------
// hes_pkg
// Shared types and constants of the height map emboss shader.
// ----------------------------------------------------------------------------
package hes_pkg;

  localparam int unsigned CFG_DW = 24;
  localparam int unsigned CFG_IW = 3;

  localparam logic [CFG_IW-1:0] REG_SLOPE   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_LIGHT_X = 3'd1;
  localparam logic [CFG_IW-1:0] REG_LIGHT_Y = 3'd2;
  localparam logic [CFG_IW-1:0] REG_LIGHT_Z = 3'd3;
  localparam logic [CFG_IW-1:0] REG_AMBIENT = 3'd4;
  localparam logic [CFG_IW-1:0] REG_DIFFUSE = 3'd5;
  localparam logic [CFG_IW-1:0] REG_WIDTH   = 3'd6;
  localparam logic [CFG_IW-1:0] REG_HEIGHT  = 3'd7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // sqrt radicand is (gx^2 + gy^2 + 1.0) << 16, at most 34 bits
  localparam int unsigned SQ_NW   = 34;
  localparam int unsigned SQ_STEP = SQ_NW / 2;
  localparam int unsigned SQ_RW   = SQ_STEP + 3;
  localparam int unsigned DV_W    = 34;

  typedef struct packed {
    logic [11:0]        slope;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic [23:0]        ambient;
    logic [23:0]        diffuse;
  } shade_cfg_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_READ,
    B_LAST,
    B_GRAD,
    B_NUM,
    B_SQRT,
    B_DIVI,
    B_DIV,
    B_MUL,
    B_SUM
  } back_state_e;

endpackage

[sv/heightmap_emboss_shader.sv]
// ----------------------------------------------------------------------------
// heightmap_emboss_shader
// Emboss bump lighting of a height map held in an on-chip frame store.
// ----------------------------------------------------------------------------
// A command word is taken when start_i is high and busy_o is low. op_i = 0
// loads height_i at the next raster position, op_i = 1 emits the next shaded
// pixel. Each emitted pixel shows on red_o/green_o/blue_o/last_pixel_o for
// one cycle with done_o high; loads give nothing.
// Commands pass through a two-word queue; busy_o is high while it is full
// and after a write of image_width, while the raster x/y counters are rebuilt.
// A load is written into the store when the back pops it in idle. A pixel
// goes through four reads through the single store port, a 17-step square
// root and an 8-step divide, skipped when the shade is zero or saturated,
// before done_o rises; the back pops no command while it shades a pixel.
// Configuration must be written through cfg_we_i/cfg_idx_i/cfg_data_i only
// while idle; the block itself does not enforce this. Reset restores register
// defaults and zeroes both positions; the store itself is not cleared.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module heightmap_emboss_shader #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       op_i,
  input  logic [7:0]                 height_i,
  input  logic                       cfg_we_i,
  input  logic [hes_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [hes_pkg::CFG_DW-1:0] cfg_data_i,
  output logic                       done_o,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o,
  output logic                       last_pixel_o
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned PW    = $clog2(DEPTH + 1);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned QW    = 10 + 4 * AW;

  hes_pkg::shade_cfg_t scfg_q;
  logic [8:0]          width_q, height_q;
  logic                push, full, pop, empty;
  logic [QW-1:0]       push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scfg_q.slope   <= 12'd256;
      scfg_q.light_x <= 16'sd9459;
      scfg_q.light_y <= 16'sd9459;
      scfg_q.light_z <= 16'sd9459;
      scfg_q.ambient <= 24'h000000;
      scfg_q.diffuse <= 24'hffffff;
      width_q        <= 9'd256;
      height_q       <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hes_pkg::REG_SLOPE:   scfg_q.slope   <= cfg_data_i[11:0];
        hes_pkg::REG_LIGHT_X: scfg_q.light_x <= cfg_data_i[15:0];
        hes_pkg::REG_LIGHT_Y: scfg_q.light_y <= cfg_data_i[15:0];
        hes_pkg::REG_LIGHT_Z: scfg_q.light_z <= cfg_data_i[15:0];
        hes_pkg::REG_AMBIENT: scfg_q.ambient <= cfg_data_i[23:0];
        hes_pkg::REG_DIFFUSE: scfg_q.diffuse <= cfg_data_i[23:0];
        hes_pkg::REG_WIDTH:   width_q        <= cfg_data_i[8:0];
        hes_pkg::REG_HEIGHT:  height_q       <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  hes_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PW        (PW),
    .AW        (AW),
    .QW        (QW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .op_i        (op_i),
    .height_i    (height_i),
    .busy_o      (busy_o),
    .width_i     (width_q),
    .height_cfg_i(height_q),
    .width_wr_i  (cfg_we_i && cfg_idx_i == hes_pkg::REG_WIDTH),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  hes_queue #(
    .DW(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_data_o (pop_data)
  );

  hes_back #(
    .AW   (AW),
    .DEPTH(DEPTH),
    .QW   (QW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (scfg_q),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .done_o      (done_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .last_pixel_o(last_pixel_o)
  );

endmodule

[sv/hes_queue.sv]
// ----------------------------------------------------------------------------
// hes_queue
// Two-entry word queue between the command front and the shading back.
// ----------------------------------------------------------------------------
module hes_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [DW-1:0] pop_data_o
);

  logic [DW-1:0] mem_q [2];
  logic          wp_q, wp_d, rp_q, rp_d;
  logic [1:0]    cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i && !full_o) begin
      wp_d = ~wp_q;
    end
    if (pop_i && !empty_o) begin
      rp_d = ~rp_q;
    end
    if ((push_i && !full_o) && !(pop_i && !empty_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!(push_i && !full_o) && (pop_i && !empty_o)) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

endmodule

[sv/hes_front.sv]
// ----------------------------------------------------------------------------
// hes_front
// Takes commands, tracks load and emit positions and works out the
// store addresses of the four neighbors of each emitted pixel.
// ----------------------------------------------------------------------------
module hes_front #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned PW         = 17,
  parameter int unsigned AW         = 16,
  parameter int unsigned QW         = 10 + 4 * AW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          op_i,
  input  logic [7:0]    height_i,
  output logic          busy_o,
  input  logic [8:0]    width_i,
  input  logic [8:0]    height_cfg_i,
  input  logic          width_wr_i,
  output logic          push_o,
  output logic [QW-1:0] push_data_o,
  input  logic          full_i
);

  localparam int unsigned CW = $clog2(PW + 1);

  logic [PW-1:0] w, h, total;
  logic [PW-1:0] lp_q, lp_d, ep_q, ep_d, x_q, x_d, y_q, y_d;
  logic [PW-1:0] lp_eff, ep_eff, x_eff, y_eff, lp_nxt, ep_nxt;
  logic [PW-1:0] a_r, a_l, a_t, a_b;
  logic          last;
  logic          accept;
  logic          rs_q, rs_d;
  logic [CW-1:0] rs_cnt_q, rs_cnt_d;
  logic [PW:0]   rs_rem_q, rs_rem_d, rs_sh;
  logic [PW-1:0] rs_num_q, rs_num_d, rs_quo_q, rs_quo_d;

  always_comb begin
    if (width_i == 9'd0) begin
      w = PW'(1);
    end else if (32'(width_i) > 32'(MAX_WIDTH)) begin
      w = PW'(MAX_WIDTH);
    end else begin
      w = PW'(width_i);
    end
    if (height_cfg_i == 9'd0) begin
      h = PW'(1);
    end else if (32'(height_cfg_i) > 32'(MAX_HEIGHT)) begin
      h = PW'(MAX_HEIGHT);
    end else begin
      h = PW'(height_cfg_i);
    end
  end

  assign total  = PW'(w * h);
  assign busy_o = full_i || rs_q;
  assign accept = start_i && !busy_o;

  assign lp_eff = (lp_q >= total) ? '0 : lp_q;
  assign ep_eff = (ep_q >= total) ? '0 : ep_q;
  assign x_eff  = (ep_q >= total) ? '0 : x_q;
  assign y_eff  = (ep_q >= total) ? '0 : y_q;
  assign lp_nxt = lp_eff + PW'(1);
  assign ep_nxt = ep_eff + PW'(1);

  assign a_r  = (x_eff == w - PW'(1)) ? ep_eff - x_eff : ep_eff + PW'(1);
  assign a_l  = (x_eff == '0) ? ep_eff + w - PW'(1) : ep_eff - PW'(1);
  assign a_t  = (y_eff == '0) ? ep_eff - w + total : ep_eff - w;
  assign a_b  = (y_eff == h - PW'(1)) ? x_eff : ep_eff + w;
  assign last = (ep_eff == total - PW'(1));

  always_comb begin
    push_o      = accept;
    push_data_o = {op_i, height_i, last, AW'(a_r), AW'(a_l), AW'(a_t), AW'(a_b)};
    if (op_i == hes_pkg::OP_LOAD) begin
      push_data_o = {op_i, height_i, 1'b0, AW'(lp_eff), AW'(a_l), AW'(a_t), AW'(a_b)};
    end
  end

  always_comb begin
    lp_d = lp_q;
    ep_d = ep_q;
    x_d  = x_q;
    y_d  = y_q;
    if (accept && op_i == hes_pkg::OP_LOAD) begin
      lp_d = (lp_nxt >= total) ? '0 : lp_nxt;
    end
    if (accept && op_i == hes_pkg::OP_EMIT) begin
      if (ep_nxt >= total) begin
        ep_d = '0;
        x_d  = '0;
        y_d  = '0;
      end else if (x_eff == w - PW'(1)) begin
        ep_d = ep_nxt;
        x_d  = '0;
        y_d  = y_eff + PW'(1);
      end else begin
        ep_d = ep_nxt;
        x_d  = x_eff + PW'(1);
        y_d  = y_eff;
      end
    end
    // re-derive x and y after a width change
    rs_d     = rs_q;
    rs_cnt_d = rs_cnt_q;
    rs_rem_d = rs_rem_q;
    rs_num_d = rs_num_q;
    rs_quo_d = rs_quo_q;
    rs_sh    = {rs_rem_q[PW-1:0], rs_num_q[PW-1]};
    if (width_wr_i) begin
      rs_d     = 1'b1;
      rs_cnt_d = '0;
      rs_rem_d = '0;
      rs_num_d = ep_q;
      rs_quo_d = '0;
    end else if (rs_q) begin
      rs_num_d = {rs_num_q[PW-2:0], 1'b0};
      if (rs_sh >= {1'b0, w}) begin
        rs_rem_d = rs_sh - {1'b0, w};
        rs_quo_d = {rs_quo_q[PW-2:0], 1'b1};
      end else begin
        rs_rem_d = rs_sh;
        rs_quo_d = {rs_quo_q[PW-2:0], 1'b0};
      end
      rs_cnt_d = rs_cnt_q + CW'(1);
      if (rs_cnt_q == CW'(PW - 1)) begin
        rs_d = 1'b0;
        x_d  = rs_rem_d[PW-1:0];
        y_d  = rs_quo_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q     <= '0;
      ep_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      rs_q     <= 1'b0;
      rs_cnt_q <= '0;
    end else begin
      lp_q     <= lp_d;
      ep_q     <= ep_d;
      x_q      <= x_d;
      y_q      <= y_d;
      rs_q     <= rs_d;
      rs_cnt_q <= rs_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_rem_q <= rs_rem_d;
    rs_num_q <= rs_num_d;
    rs_quo_q <= rs_quo_d;
  end

endmodule

[sv/hes_back.sv]
// ----------------------------------------------------------------------------
// hes_back
// Frame store and shading datapath: neighbor reads, gradients, normal
// length by bit-serial square root, restoring divide and color blend.
// ----------------------------------------------------------------------------
module hes_back #(
  parameter int unsigned AW    = 16,
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned QW    = 10 + 4 * AW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hes_pkg::shade_cfg_t cfg_i,
  input  logic                empty_i,
  input  logic [QW-1:0]       pop_data_i,
  output logic                pop_o,
  output logic                done_o,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic                last_pixel_o
);

  localparam int unsigned NW = hes_pkg::SQ_NW;
  localparam int unsigned RW = hes_pkg::SQ_RW;
  localparam int unsigned DW = hes_pkg::DV_W;

  hes_pkg::back_state_e st_q, st_d;

  logic [7:0]    mem_q [DEPTH];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;

  logic              op;
  logic [7:0]        wdata;
  logic              last_in;
  logic [AW-1:0]     a_in [4];
  logic [AW-1:0]     a_q [4];
  logic              last_q;
  logic [1:0]        rc_q, rc_d;
  logic [7:0]        hv_q [4];

  logic signed [8:0]  dx, dy;
  logic signed [21:0] px, py;
  logic signed [9:0]  gx_d, gy_d, gx_q, gy_q;
  logic signed [27:0] num_d, num_q;
  logic [NW-1:0]      rad_d;
  logic [NW-1:0]      rad_q;
  logic [RW-1:0]      srem_q, srem_sh, strial;
  logic [RW-1:0]      root_q;
  logic [4:0]         sc_q;
  logic [DW-1:0]      drem_q, dden;
  logic [DW-1:0]      dnum;
  logic [2:0]         dc_q;
  logic [7:0]         v_q;
  logic [15:0]        mr_q, mg_q, mb_q;
  logic               done_q;

  function automatic logic signed [9:0] grad(input logic signed [21:0] p);
    logic signed [21:0] c;
    logic signed [21:0] t;
    begin
      c = p;
      if (p > 22'sd65536) c = 22'sd65536;
      if (p < -22'sd65536) c = -22'sd65536;
      t = (c < 0) ? c + 22'sd255 : c;
      grad = 10'(t >>> 8);
    end
  endfunction

  function automatic logic [7:0] blend(input logic [7:0] a, input logic [15:0] m);
    logic [8:0] s;
    begin
      s = {1'b0, a} + {1'b0, m[15:8]};
      blend = s[8] ? 8'hff : s[7:0];
    end
  endfunction

  assign op      = pop_data_i[QW-1];
  assign wdata   = pop_data_i[QW-2 -: 8];
  assign last_in = pop_data_i[4*AW];
  assign a_in[0] = pop_data_i[4*AW-1 -: AW];
  assign a_in[1] = pop_data_i[3*AW-1 -: AW];
  assign a_in[2] = pop_data_i[2*AW-1 -: AW];
  assign a_in[3] = pop_data_i[AW-1:0];

  assign dx = $signed({1'b0, hv_q[0]}) - $signed({1'b0, hv_q[1]});
  assign dy = $signed({1'b0, hv_q[2]}) - $signed({1'b0, hv_q[3]});
  assign px = 22'(dx * $signed({1'b0, cfg_i.slope}));
  assign py = 22'(dy * $signed({1'b0, cfg_i.slope}));
  assign gx_d = grad(px);
  assign gy_d = grad(py);

  assign num_d = 28'(cfg_i.light_x * gx_q) + 28'(cfg_i.light_y * gy_q)
               + (28'(cfg_i.light_z) <<< 8);
  assign rad_d = NW'({12'd0, 20'(gx_q * gx_q) + 20'(gy_q * gy_q) + 20'd65536} << 16);

  assign srem_sh = {srem_q[RW-3:0], rad_q[NW-1 -: 2]};
  assign strial  = {root_q[RW-3:0], 2'b01};
  assign dnum    = DW'(num_q) * DW'(255);
  assign dden    = DW'(root_q) << 6;

  always_comb begin
    st_d     = st_q;
    rc_d     = rc_q;
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    mem_addr = a_q[rc_q];
    case (st_q)
      hes_pkg::B_IDLE: begin
        mem_addr = a_in[0];
        if (!empty_i) begin
          pop_o = 1'b1;
          if (op == hes_pkg::OP_LOAD) begin
            mem_we = 1'b1;
          end else begin
            st_d = hes_pkg::B_READ;
            rc_d = 2'd0;
          end
        end
      end
      hes_pkg::B_READ: begin
        rc_d = rc_q + 2'd1;
        if (rc_q == 2'd3) st_d = hes_pkg::B_LAST;
      end
      hes_pkg::B_LAST: st_d = hes_pkg::B_GRAD;
      hes_pkg::B_GRAD: st_d = hes_pkg::B_NUM;
      hes_pkg::B_NUM:  st_d = hes_pkg::B_SQRT;
      hes_pkg::B_SQRT: if (sc_q == 5'(hes_pkg::SQ_STEP - 1)) st_d = hes_pkg::B_DIVI;
      hes_pkg::B_DIVI: begin
        if (num_q <= 0 || dnum >= (dden << 8)) st_d = hes_pkg::B_MUL;
        else st_d = hes_pkg::B_DIV;
      end
      hes_pkg::B_DIV:  if (dc_q == 3'd0) st_d = hes_pkg::B_MUL;
      hes_pkg::B_MUL:  st_d = hes_pkg::B_SUM;
      hes_pkg::B_SUM:  st_d = hes_pkg::B_IDLE;
      default:         st_d = hes_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= hes_pkg::B_IDLE;
      rc_q   <= 2'd0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      rc_q   <= rc_d;
      done_q <= (st_q == hes_pkg::B_SUM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      hes_pkg::B_IDLE: begin
        a_q    <= a_in;
        last_q <= last_in;
      end
      hes_pkg::B_READ: if (rc_q != 2'd0) hv_q[rc_q - 2'd1] <= rdata_q;
      hes_pkg::B_LAST: hv_q[3] <= rdata_q;
      hes_pkg::B_GRAD: begin
        gx_q <= gx_d;
        gy_q <= gy_d;
      end
      hes_pkg::B_NUM: begin
        num_q  <= num_d;
        rad_q  <= rad_d;
        srem_q <= '0;
        root_q <= '0;
        sc_q   <= 5'd0;
      end
      hes_pkg::B_SQRT: begin
        rad_q <= rad_q << 2;
        sc_q  <= sc_q + 5'd1;
        if (srem_sh >= strial) begin
          srem_q <= srem_sh - strial;
          root_q <= {root_q[RW-2:0], 1'b1};
        end else begin
          srem_q <= srem_sh;
          root_q <= {root_q[RW-2:0], 1'b0};
        end
      end
      hes_pkg::B_DIVI: begin
        drem_q <= dnum;
        dc_q   <= 3'd7;
        v_q    <= (num_q > 0 && dnum >= (dden << 8)) ? 8'hff : 8'd0;
      end
      hes_pkg::B_DIV: begin
        dc_q <= dc_q - 3'd1;
        if (drem_q >= (dden << dc_q)) begin
          drem_q      <= drem_q - (dden << dc_q);
          v_q[dc_q]   <= 1'b1;
        end
      end
      hes_pkg::B_MUL: begin
        mr_q <= cfg_i.diffuse[23:16] * v_q;
        mg_q <= cfg_i.diffuse[15:8] * v_q;
        mb_q <= cfg_i.diffuse[7:0] * v_q;
      end
      hes_pkg::B_SUM: begin
        red_o        <= blend(cfg_i.ambient[23:16], mr_q);
        green_o      <= blend(cfg_i.ambient[15:8], mg_q);
        blue_o       <= blend(cfg_i.ambient[7:0], mb_q);
        last_pixel_o <= last_q;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

  a_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (st_q == hes_pkg::B_IDLE && !empty_i))
    else $error("store write outside idle");

  a_done_after_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(st_q) == hes_pkg::B_SUM)
    else $error("result strobe without blend step");

endmodule

[tb/hes_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hes_checker
// Watches the command, configuration and pixel channels of the emboss shader,
// keeps its own frame store and register copy, predicts every shaded pixel
// and compares it field by field with what the block emits.
// ----------------------------------------------------------------------------
module hes_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       op_i,
  input  logic [7:0]                 height_i,
  input  logic                       cfg_we_i,
  input  logic [hes_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [hes_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                       done_i,
  input  logic [7:0]                 red_i,
  input  logic [7:0]                 green_i,
  input  logic [7:0]                 blue_i,
  input  logic                       last_pixel_i,
  output int                         mismatches_o,
  output int                         pending_o,
  output int                         pixels_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  pixel_t             pixel_q[$];
  logic [7:0]         frame_mem [0:65535];
  int unsigned        load_pos, emit_pos;
  logic [11:0]        slope;
  logic signed [15:0] lx, ly, lz;
  logic [23:0]        amb, dif;
  logic [8:0]         wreg, hreg;

  assign pending_o = pixel_q.size();

  function automatic int unsigned clamp_dim(logic [8:0] v);
    if (v < 1) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic int slope_grad(int d);
    int p;
    p = d * int'(slope);
    if (p > 65536) p = 65536;
    if (p < -65536) p = -65536;
    return p / 256;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] tint(logic [7:0] a, logic [7:0] c, int unsigned v);
    int unsigned s;
    s = a + ((c * v) >> 8);
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  function automatic pixel_t shade_next();
    int unsigned     w, h, total, p, x, y, ir, il, it, ib, v;
    int              gx, gy;
    longint          num;
    longint unsigned r, q;
    pixel_t          px;
    w = clamp_dim(wreg);
    h = clamp_dim(hreg);
    total = w * h;
    p = (emit_pos >= total) ? 0 : emit_pos;
    x = p % w;
    y = p / w;
    ir = (x == w - 1) ? y * w : p + 1;
    il = (x == 0) ? p + w - 1 : p - 1;
    it = (y == 0) ? p + w * (h - 1) : p - w;
    ib = (y == h - 1) ? x : p + w;
    gx = slope_grad(int'(frame_mem[ir]) - int'(frame_mem[il]));
    gy = slope_grad(int'(frame_mem[it]) - int'(frame_mem[ib]));
    r = int_sqrt(longint'(gx * gx + gy * gy + 65536) << 16);
    num = longint'(lx) * gx + longint'(ly) * gy + longint'(lz) * 256;
    if (num <= 0) begin
      v = 0;
    end else begin
      q = (longint'(num) * 255) / (64 * r);
      v = (q > 255) ? 255 : q;
    end
    px.red   = tint(amb[23:16], dif[23:16], v);
    px.green = tint(amb[15:8], dif[15:8], v);
    px.blue  = tint(amb[7:0], dif[7:0], v);
    px.last  = (p == total - 1);
    emit_pos = (p + 1 >= total) ? 0 : p + 1;
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t      want, got;
    int unsigned total, p;
    if (!rst_ni) begin
      pixel_q.delete();
      load_pos = 0;
      emit_pos = 0;
      slope = 12'd256;
      lx = 16'sd9459;
      ly = 16'sd9459;
      lz = 16'sd9459;
      amb = 24'h000000;
      dif = 24'hFFFFFF;
      wreg = 9'd256;
      hreg = 9'd256;
      mismatches_o = 0;
      pixels_o = 0;
    end else begin
      if (done_i) begin
        got = '{red_i, green_i, blue_i, last_pixel_i};
        pixels_o++;
        if (pixel_q.size() == 0) begin
          $display("%0t unexpected pixel word: actual r=%0d g=%0d b=%0d last=%0d",
                   $time, got.red, got.green, got.blue, got.last);
          mismatches_o++;
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            $display("%0t pixel mismatch: expected r=%0d g=%0d b=%0d last=%0d,",
                     $time, want.red, want.green, want.blue, want.last);
            $display("  actual r=%0d g=%0d b=%0d last=%0d",
                     got.red, got.green, got.blue, got.last);
            mismatches_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hes_pkg::REG_SLOPE:   slope = cfg_data_i[11:0];
          hes_pkg::REG_LIGHT_X: lx = cfg_data_i[15:0];
          hes_pkg::REG_LIGHT_Y: ly = cfg_data_i[15:0];
          hes_pkg::REG_LIGHT_Z: lz = cfg_data_i[15:0];
          hes_pkg::REG_AMBIENT: amb = cfg_data_i[23:0];
          hes_pkg::REG_DIFFUSE: dif = cfg_data_i[23:0];
          hes_pkg::REG_WIDTH:   wreg = cfg_data_i[8:0];
          hes_pkg::REG_HEIGHT:  hreg = cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (op_i == hes_pkg::OP_LOAD) begin
          total = clamp_dim(wreg) * clamp_dim(hreg);
          p = (load_pos >= total) ? 0 : load_pos;
          frame_mem[p] = height_i;
          load_pos = (p + 1 >= total) ? 0 : p + 1;
        end else begin
          pixel_q.push_back(shade_next());
        end
      end
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the emboss shader: a directed small frame, then phases of
// fixed and random register settings, each with every frame position loaded
// before random loads and pixel emits under varying sender gaps; checker verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IDLE_LIMIT = 5000;
  localparam int PHASES     = 10;
  localparam int RAND_ITEMS = 128;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic                       op_i = hes_pkg::OP_LOAD;
  logic [7:0]                 height_i = '0;
  logic                       cfg_we_i = 1'b0;
  logic [hes_pkg::CFG_IW-1:0] cfg_idx_i = hes_pkg::REG_SLOPE;
  logic [hes_pkg::CFG_DW-1:0] cfg_data_i = '0;
  logic                       busy_o, done_o, last_pixel_o;
  logic [7:0]                 red_o, green_o, blue_o;
  int                         mismatches, pending, pixels;
  int                         idle_cycles = 0;
  int                         idle_pct = 0;
  int unsigned                cur_w = 256, cur_h = 256, load_pos = 0, filled = 0;
  int                         n_loads = 0, n_emits = 0;

  always #5 clk_i = ~clk_i;

  heightmap_emboss_shader DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .height_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .done_o, .red_o, .green_o, .blue_o, .last_pixel_o
  );

  hes_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .op_i, .height_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .done_i(done_o), .red_i(red_o), .green_i(green_o), .blue_i(blue_o),
    .last_pixel_i(last_pixel_o),
    .mismatches_o(mismatches), .pending_o(pending), .pixels_o(pixels)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int unsigned dim_of(logic [8:0] v);
    if (v < 1) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  task automatic send_word(logic op, logic [7:0] h);
    logic        hold;
    int unsigned p;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= op;
    height_i <= h;
    do begin
      @(negedge clk_i);
      hold = busy_o;
      @(posedge clk_i);
    end while (hold);
    if (op == hes_pkg::OP_LOAD) begin
      p = (load_pos >= cur_w * cur_h) ? 0 : load_pos;
      if (p + 1 > filled) filled = p + 1;
      load_pos = (p + 1 >= cur_w * cur_h) ? 0 : p + 1;
      n_loads++;
    end else begin
      n_emits++;
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [hes_pkg::CFG_IW-1:0] idx,
                           logic [hes_pkg::CFG_DW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == hes_pkg::REG_WIDTH) cur_w = dim_of(data[8:0]);
    if (idx == hes_pkg::REG_HEIGHT) cur_h = dim_of(data[8:0]);
  endtask

  function automatic logic [7:0] rand_height();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic logic [15:0] rand_light();
    int v;
    v = int'($urandom_range(32768)) - 16384;
    return v[15:0];
  endfunction

  initial begin
    logic [8:0]  dims_w [PHASES] = '{1, 0, 511, 1, 5, 16, 3, 2, 8, 13};
    logic [8:0]  dims_h [PHASES] = '{1, 0, 1, 300, 7, 8, 2, 9, 8, 4};
    logic [7:0]  dir_h [12] = '{0, 255, 128, 1, 254, 7, 0, 255, 255, 0, 64, 200};
    int          modes [3] = '{0, 60, 7};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: small frame with steep edges, full and zero slope
    write_reg(hes_pkg::REG_WIDTH, 4);
    write_reg(hes_pkg::REG_HEIGHT, 3);
    write_reg(hes_pkg::REG_SLOPE, 4095);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    for (int i = 0; i < 12; i++) send_word(hes_pkg::OP_LOAD, dir_h[i]);
    for (int i = 0; i < 6; i++) send_word(hes_pkg::OP_EMIT, 8'd0);
    drain();
    write_reg(hes_pkg::REG_LIGHT_X, 16'h4000);
    write_reg(hes_pkg::REG_LIGHT_Y, 16'hC000);
    write_reg(hes_pkg::REG_LIGHT_Z, 16'h4000);
    write_reg(hes_pkg::REG_SLOPE, 0);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    for (int i = 0; i < 6; i++) send_word(hes_pkg::OP_EMIT, 8'd0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(hes_pkg::REG_WIDTH, dims_w[ph]);
      write_reg(hes_pkg::REG_HEIGHT, dims_h[ph]);
      if (ph == 0) begin
        write_reg(hes_pkg::REG_SLOPE, 0);
        write_reg(hes_pkg::REG_LIGHT_X, 16'hC000);
        write_reg(hes_pkg::REG_LIGHT_Y, 16'hC000);
        write_reg(hes_pkg::REG_LIGHT_Z, 16'hC000);
        write_reg(hes_pkg::REG_AMBIENT, 24'h000000);
        write_reg(hes_pkg::REG_DIFFUSE, 24'h000000);
      end else if (ph == 1) begin
        write_reg(hes_pkg::REG_SLOPE, 4095);
        write_reg(hes_pkg::REG_LIGHT_X, 16'h4000);
        write_reg(hes_pkg::REG_LIGHT_Y, 16'h4000);
        write_reg(hes_pkg::REG_LIGHT_Z, 16'h4000);
        write_reg(hes_pkg::REG_AMBIENT, 24'hFFFFFF);
        write_reg(hes_pkg::REG_DIFFUSE, 24'hFFFFFF);
      end else begin
        write_reg(hes_pkg::REG_SLOPE,
                  ($urandom_range(1)) ? $urandom_range(4095) : $urandom_range(512));
        write_reg(hes_pkg::REG_LIGHT_X, rand_light());
        write_reg(hes_pkg::REG_LIGHT_Y, rand_light());
        write_reg(hes_pkg::REG_LIGHT_Z,
                  ($urandom_range(3) == 0) ? rand_light() : $urandom_range(16384));
        write_reg(hes_pkg::REG_AMBIENT,
                  ($urandom_range(1)) ? $urandom_range(24'hFFFFFF) : '0);
        write_reg(hes_pkg::REG_DIFFUSE, $urandom_range(24'hFFFFFF));
      end
      cfg_we_i <= 1'b0;
      idle_pct = modes[ph % 3];
      @(posedge clk_i);
      while (filled < cur_w * cur_h) send_word(hes_pkg::OP_LOAD, rand_height());
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if ($urandom_range(99) < 70) send_word(hes_pkg::OP_EMIT, $urandom_range(255));
        else send_word(hes_pkg::OP_LOAD, rand_height());
      end
      drain();
    end

    $display("covered %0d loads and %0d pixel emits over %0d register settings",
             n_loads, n_emits, PHASES + 2);
    $display("pixels checked: %0d, frames from 1x1 up to 256 wide and 256 tall", pixels);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      if (pending != 0) $display("%0t %0d expected pixel words never arrived", $time, pending);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
